// ----- rtl/core/tfr_pkg.sv -----
// Shared types, constants and helpers for the Threefry-4x32 random unit.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package tfr_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 24;
    localparam int NUM_WORDS  = 4;
    localparam int NUM_SCHED  = 5;
    localparam int NUM_ROUNDS = 20;
    // one key injection stage followed by one stage per round
    localparam int NUM_STAGES = NUM_ROUNDS + 1;

    localparam logic [WORD_W-1:0] KEY_PARITY = 32'h1BD1_1BDA;

    typedef logic [WORD_W-1:0]      word_t;
    typedef word_t [NUM_WORDS-1:0]  block_t;
    typedef word_t [NUM_SCHED-1:0]  sched_t;

    typedef enum logic [1:0] {
        REG_KEY_WORD_0 = 2'd0,
        REG_KEY_WORD_1 = 2'd1,
        REG_KEY_WORD_2 = 2'd2,
        REG_KEY_WORD_3 = 2'd3
    } cfg_reg_t;

    // rotation for the first pair of a round
    function automatic int unsigned rot_first(int unsigned idx);
        int unsigned r;
        case (idx)
            0:       r = 10;
            1:       r = 11;
            2:       r = 13;
            3:       r = 23;
            4:       r = 6;
            5:       r = 17;
            6:       r = 25;
            7:       r = 18;
            default: r = 1;
        endcase
        return r;
    endfunction

    // rotation for the second pair of a round
    function automatic int unsigned rot_second(int unsigned idx);
        int unsigned r;
        case (idx)
            0:       r = 26;
            1:       r = 21;
            2:       r = 27;
            3:       r = 5;
            4:       r = 20;
            5:       r = 11;
            6:       r = 10;
            7:       r = 20;
            default: r = 1;
        endcase
        return r;
    endfunction

    // rotate left by a constant amount in 1..WORD_W-1
    function automatic word_t rotl(word_t v, int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage

// ----- rtl/core/tfr_key.sv -----
// Key registers and the five-word key schedule (four keys plus parity).
// Depends on tfr_pkg.
`timescale 1ns / 1ps

module tfr_key (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [31:0]          cfg_wdata,
    output tfr_pkg::sched_t      ks
);
    import tfr_pkg::*;

    block_t key_reg;
    block_t key_next;

    always_comb begin
        key_next = key_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_KEY_WORD_0: key_next[0] = cfg_wdata;
                REG_KEY_WORD_1: key_next[1] = cfg_wdata;
                REG_KEY_WORD_2: key_next[2] = cfg_wdata;
                REG_KEY_WORD_3: key_next[3] = cfg_wdata;
                default:        key_next    = key_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            key_reg <= key_next;
        end
    end

    assign ks[0] = key_reg[0];
    assign ks[1] = key_reg[1];
    assign ks[2] = key_reg[2];
    assign ks[3] = key_reg[3];
    assign ks[4] = KEY_PARITY ^ key_reg[0] ^ key_reg[1] ^ key_reg[2] ^ key_reg[3];

endmodule

// ----- rtl/core/tfr_stage.sv -----
// One pipeline stage: stage 0 injects the key, stage n runs round n-1
// and, after every fourth round, the next key injection. Depends on tfr_pkg.
`timescale 1ns / 1ps

module tfr_stage #(
    parameter int STAGE = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             in_valid,
    input  tfr_pkg::block_t  in_block,
    input  tfr_pkg::sched_t  ks,
    output logic             out_valid,
    output tfr_pkg::block_t  out_block
);
    import tfr_pkg::*;

    localparam bit          DO_MIX = (STAGE > 0);
    localparam int unsigned RIDX   = DO_MIX ? (STAGE - 1) % 8 : 0;
    localparam bit          ODD_R  = DO_MIX ? (((STAGE - 1) % 2) == 1) : 1'b0;
    localparam int unsigned ROT_A  = rot_first(RIDX);
    localparam int unsigned ROT_B  = rot_second(RIDX);
    localparam bit          DO_INJ = ((STAGE % 4) == 0);
    localparam int          INJ_S  = STAGE / 4;
    localparam int          KI0    = (INJ_S + 0) % NUM_SCHED;
    localparam int          KI1    = (INJ_S + 1) % NUM_SCHED;
    localparam int          KI2    = (INJ_S + 2) % NUM_SCHED;
    localparam int          KI3    = (INJ_S + 3) % NUM_SCHED;

    logic   valid_reg;
    block_t block_reg;
    block_t mixed;
    block_t block_next;

    always_comb begin
        mixed = in_block;
        if (DO_MIX) begin
            if (!ODD_R) begin
                mixed[0] = in_block[0] + in_block[1];
                mixed[1] = rotl(in_block[1], ROT_A) ^ mixed[0];
                mixed[2] = in_block[2] + in_block[3];
                mixed[3] = rotl(in_block[3], ROT_B) ^ mixed[2];
            end else begin
                mixed[0] = in_block[0] + in_block[3];
                mixed[3] = rotl(in_block[3], ROT_A) ^ mixed[0];
                mixed[2] = in_block[2] + in_block[1];
                mixed[1] = rotl(in_block[1], ROT_B) ^ mixed[2];
            end
        end
    end

    always_comb begin
        block_next = mixed;
        if (DO_INJ) begin
            block_next[0] = mixed[0] + ks[KI0];
            block_next[1] = mixed[1] + ks[KI1];
            block_next[2] = mixed[2] + ks[KI2];
            // word 3 also takes the injection number
            block_next[3] = mixed[3] + ks[KI3] + WORD_W'(INJ_S);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            block_reg <= block_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_block = block_reg;

endmodule

// ----- rtl/core/counter_based_rng_unit_float_core.sv -----
// Top level of the Threefry-4x32-20 counter-based random unit.
// Depends on tfr_pkg, tfr_key and tfr_stage.
//
//   Channel   Ports                        Payload
//   input     s_tvalid s_tready s_tdata    128-bit counter, one item per block
//   result    m_tvalid m_tready m_tdata    four Q0.24 fractions
//   config    cfg_we cfg_addr cfg_wdata    key words 0..3
//
// One item may enter every cycle while the pipeline is not held; the path is one key injection
// stage plus one stage per round, the last stage being the output register.
// Reset clears all stage valid bits and the key to zero.
// The whole pipeline advances when the output register is empty or taken;
// s_tready drops only while a result waits and m_tready is low.
`timescale 1ns / 1ps

module counter_based_rng_unit_float_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // counter_word_0, counter_word_1, counter_word_2, counter_word_3
    input  logic [127:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // fraction_0, fraction_1, fraction_2, fraction_3
    output logic [95:0]   m_tdata,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_addr,
    input  logic [31:0]   cfg_wdata
);
    import tfr_pkg::*;

    sched_t ks;
    logic   advance;
    logic   valid_pipe [NUM_STAGES+1];
    block_t block_pipe [NUM_STAGES+1];

    tfr_key u_key (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ks        (ks)
    );

    assign valid_pipe[0] = s_tvalid;
    assign block_pipe[0] = s_tdata;

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        tfr_stage #(
            .STAGE (g)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (valid_pipe[g]),
            .in_block  (block_pipe[g]),
            .ks        (ks),
            .out_valid (valid_pipe[g+1]),
            .out_block (block_pipe[g+1])
        );
    end

    // hold everything while a result waits and m_tready is low
    assign advance  = !valid_pipe[NUM_STAGES] || m_tready;
    assign s_tready = advance;
    assign m_tvalid = valid_pipe[NUM_STAGES];

    assign m_tdata = {block_pipe[NUM_STAGES][3][WORD_W-1 -: FRAC_W],
                      block_pipe[NUM_STAGES][2][WORD_W-1 -: FRAC_W],
                      block_pipe[NUM_STAGES][1][WORD_W-1 -: FRAC_W],
                      block_pipe[NUM_STAGES][0][WORD_W-1 -: FRAC_W]};

endmodule
